@@ sv/pkst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkst_pkg
// Types and constants shared by the port-knock sequence tracker.
// ----------------------------------------------------------------------------
package pkst_pkg;

  localparam int PORT_W     = 16;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 8;
  localparam int SLOT_IDX_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_SEQ    = 4;
  localparam int WIDE_W     = 64;

  localparam logic [CNT_W-1:0] CNT_MAX  = 8'hFF;
  localparam logic [CNT_W-1:0] CNT_WRAP = 8'h01;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_PORT_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_PORT_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_PORT_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_PORT_D = 2'd3;

  typedef enum logic [1:0] {
    OP_KNOCK = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [PORT_W-1:0]     dest_port;
    logic [DATA_W-1:0]     chunk_data;
    logic [SLOT_IDX_W-1:0] slot_index;
  } knock_req_t;

  typedef struct packed {
    logic                  status;
    logic [SLOT_IDX_W-1:0] slot;
    logic [CNT_W-1:0]      hit_count;
    logic [DATA_W-1:0]     slot_data;
    logic                  all_hit;
  } knock_rsp_t;

endpackage

@@ sv/port_knock_sequence_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_knock_sequence_tracker_core
// Follows one client's knock attempt against four configured ports.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready/in_data, results leave on
//   out_valid/out_ready/out_data; each request yields one result.
//   Sequence ports are written through cfg_wr_en/cfg_addr/cfg_wdata while
//   the block is idle.
//   At the accept edge the port match is captured and the slot memory read
//   starts; the edge that leaves ST_EXEC, once the output register is free,
//   writes the slot back, loads the output register and raises out_valid.
//   A new request is not taken until the current one has left ST_EXEC.
//   The output register holds a result while the receiver stalls; the next
//   request is still accepted, and its write-back waits until the output
//   register frees up.
//   Reset clears the sequence ports and the per-slot hit flags; a slot that
//   is not flagged reads as zero count and zero data, so the memory itself
//   needs no clearing pass. A clear request drops all flags.
// ----------------------------------------------------------------------------
module port_knock_sequence_tracker_core
  import pkst_pkg::*;
#(
  parameter int NUM_SLOTS  = 4,
  parameter int CHUNK_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  knock_req_t           in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output knock_rsp_t           out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [PORT_W-1:0]    cfg_wdata
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MEM_W  = CNT_W + CHUNK_BITS;

  logic [PORT_W-1:0] seq_port [NUM_SEQ];

  logic [MEM_W-1:0]  mem [NUM_SLOTS];
  logic [MEM_W-1:0]  rd_word;
  logic [NUM_SLOTS-1:0] valid;
  logic [NUM_SLOTS-1:0] valid_next;

  state_t state, state_next;
  logic   accept;
  logic   go;

  logic                  match_hit;
  logic [SLOT_W-1:0]     match_idx;
  logic [SLOT_W-1:0]     rd_addr;

  logic [1:0]            req_op;
  logic                  req_hit;
  logic                  req_active;
  logic [SLOT_IDX_W-1:0] req_slot;
  logic [SLOT_W-1:0]     req_addr;
  logic [DATA_W-1:0]     req_chunk;

  logic [CNT_W-1:0]      cur_cnt;
  logic [CHUNK_BITS-1:0] cur_chunk;
  logic [CNT_W-1:0]      new_cnt;
  logic [CHUNK_BITS-1:0] new_chunk;
  logic [WIDE_W-1:0]     chunk_wide;
  logic [WIDE_W-1:0]     store_wide;
  logic [WIDE_W-1:0]     new_wide;
  logic                  mem_we;
  knock_rsp_t            rsp_next;

  // sequence port registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SEQ; i++) begin
        seq_port[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_SEQ_PORT_A: seq_port[0] <= cfg_wdata;
        CFG_SEQ_PORT_B: seq_port[1] <= cfg_wdata;
        CFG_SEQ_PORT_C: seq_port[2] <= cfg_wdata;
        CFG_SEQ_PORT_D: seq_port[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // lowest matching slot wins
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (seq_port[i] == in_data.dest_port) begin
        match_hit = 1'b1;
        match_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    if (in_data.op == OP_KNOCK) begin
      rd_addr = match_idx;
    end else begin
      rd_addr = in_data.slot_index[SLOT_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    go         = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid || out_ready) begin
          go         = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = in_valid && in_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op     <= in_data.op;
      req_hit    <= match_hit;
      req_active <= (in_data.op == OP_KNOCK) || (int'(in_data.slot_index) < NUM_SLOTS);
      req_slot   <= (in_data.op == OP_KNOCK) ? SLOT_IDX_W'(match_idx) : in_data.slot_index;
      req_addr   <= rd_addr;
      req_chunk  <= in_data.chunk_data;
    end
  end

  // slot memory: count and chunk per entry
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[req_addr] <= {new_cnt, new_chunk};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (go) begin
      valid <= valid_next;
    end
  end

  // read-modify-write
  always_comb begin
    if (req_active && valid[req_addr]) begin
      cur_cnt   = rd_word[MEM_W-1 -: CNT_W];
      cur_chunk = rd_word[CHUNK_BITS-1:0];
    end else begin
      cur_cnt   = '0;
      cur_chunk = '0;
    end
    chunk_wide = WIDE_W'(req_chunk);
    new_chunk  = chunk_wide[CHUNK_BITS-1:0];
    new_cnt    = (cur_cnt == CNT_MAX) ? CNT_WRAP : cur_cnt + 1'b1;
    store_wide = WIDE_W'(cur_chunk);
    new_wide   = WIDE_W'(new_chunk);

    mem_we     = 1'b0;
    valid_next = valid;
    rsp_next   = '0;
    rsp_next.status = STATUS_OK;

    case (req_op)
      OP_KNOCK: begin
        if (req_hit) begin
          mem_we              = go;
          valid_next[req_addr] = 1'b1;
          rsp_next.slot       = req_slot;
          rsp_next.hit_count  = new_cnt;
          rsp_next.slot_data  = new_wide[DATA_W-1:0];
        end else begin
          rsp_next.status = STATUS_MISS;
        end
      end
      OP_CLEAR: begin
        valid_next = '0;
      end
      default: begin
        rsp_next.slot      = req_slot;
        rsp_next.hit_count = cur_cnt;
        rsp_next.slot_data = store_wide[DATA_W-1:0];
      end
    endcase
    rsp_next.all_hit = &valid_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= rsp_next;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_all_hit_tracks_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.all_hit == (&valid)))
    else $error("all_hit disagrees with slot flags");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == STATUS_MISS) |->
      (out_data.hit_count == '0 && out_data.slot_data == '0 && out_data.slot == '0))
    else $error("miss result carries slot fields");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (go && req_op == OP_KNOCK && req_hit) |=> (out_valid && out_data.hit_count != '0))
    else $error("matched knock produced zero count");

  a_clear_flags: assert property (@(posedge clk) disable iff (rst)
    (go && req_op == OP_CLEAR) |=> (valid == '0))
    else $error("clear left a slot flagged");

endmodule
